// ===== rtl/ase_pkg.sv =====
// ----------------------------------------------------------------------------
// ase_pkg
// Shared types and constants for the advertising element extractor.
// ----------------------------------------------------------------------------
package ase_pkg;

    localparam logic [7:0] TYPE_RESET = 8'hff;

    typedef enum logic [2:0] {
        PH_LEN     = 3'd0,
        PH_TYPE    = 3'd1,
        PH_SKIP    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4,
        PH_BAD     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        OUT_FOUND  = 2'd0,
        OUT_ABSENT = 2'd1,
        OUT_BAD    = 2'd2
    } t_outcome;

    typedef struct packed {
        logic       is_summary;
        logic [7:0] data_byte;
        t_outcome   outcome;
        logic [6:0] payload_length;
        logic       final_res;
    } t_result;

    // up to two results per record byte: r0 first, r1 only with r0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

// ===== rtl/ad_structure_type_extractor.sv =====
// ----------------------------------------------------------------------------
// ad_structure_type_extractor
// Walks an advertising record byte by byte and extracts the payload of the
// first element whose type matches the configured target.
// ----------------------------------------------------------------------------
// One record byte is taken per cycle while the queue has room. A taken byte
// passes through the input register and then into the result queue, from
// whose head its result is presented. Each byte yields at most one result,
// except a final byte that is also a payload byte, which yields the payload
// result and then the summary; those two leave the queue one after the other.
// Results wait in a queue of RES_DEPTH entries, and a byte moves from the
// input register into the parser only while the queue has two free entries,
// so with a consumer that is always ready the sustained rate is one byte per
// cycle. target_type is to be written through i_cfg_we/i_cfg_data only
// while the block is idle, not enforced by the block; it resets to 0xff.
module ad_structure_type_extractor
    import ase_pkg::*;
#(
    parameter int RES_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ad_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_summary,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_outcome,
    output logic [6:0] o_payload_length,
    output logic       o_final_res
);

    logic [7:0] r_target;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       room;
    logic       go;
    t_push      push;
    t_result    res;

    assign go      = r_in_valid && room;
    assign o_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TYPE_RESET;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
    end

    // request payload register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_ad_byte;
            r_in_last <= i_last_byte;
        end
    end

    ase_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_target (r_target),
        .o_push   (push)
    );

    ase_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_is_summary     = res.is_summary;
    assign o_data_byte      = res.data_byte;
    assign o_outcome        = res.outcome;
    assign o_payload_length = res.payload_length;
    assign o_final_res      = res.final_res;

endmodule

// ===== rtl/ase_parser.sv =====
// ----------------------------------------------------------------------------
// ase_parser
// Per-byte element walker: tracks length/type/value phases of the record and
// produces the payload results and, on the last byte, the summary result.
// ----------------------------------------------------------------------------
module ase_parser
    import ase_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [7:0] i_target,
    output t_push      o_push
);

    t_phase     r_phase,     n_phase,     st_phase;
    logic [6:0] r_remaining, n_remaining, st_remaining;
    logic [6:0] r_elen,      n_elen,      st_elen;
    t_outcome   r_verdict,   n_verdict,   st_verdict;
    logic [6:0] rem_dec;

    assign rem_dec = r_remaining - 7'd1;

    // next state
    always_comb begin
        st_phase     = r_phase;
        st_remaining = r_remaining;
        st_elen      = r_elen;
        st_verdict   = r_verdict;
        unique case (r_phase)
            PH_LEN: begin
                if (i_byte == 8'd0 || i_byte[7] || i_last) begin
                    st_phase   = PH_BAD;
                    st_verdict = OUT_BAD;
                end else begin
                    st_elen  = i_byte[6:0];
                    st_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                st_remaining = r_elen - 7'd1;
                if (i_byte == i_target) begin
                    if (st_remaining == 7'd0) begin
                        st_phase   = PH_DONE;
                        st_verdict = OUT_ABSENT;
                    end else begin
                        st_phase   = PH_PAYLOAD;
                        st_verdict = OUT_FOUND;
                    end
                end else begin
                    st_phase = (st_remaining == 7'd0) ? PH_LEN : PH_SKIP;
                end
            end
            PH_SKIP, PH_PAYLOAD: begin
                st_remaining = rem_dec;
                if (rem_dec == 7'd0) begin
                    st_phase = (r_phase == PH_PAYLOAD) ? PH_DONE : PH_LEN;
                end
            end
            default: begin
            end
        endcase

        if (i_last) begin
            n_phase     = PH_LEN;
            n_remaining = 7'd0;
            n_elen      = 7'd0;
            n_verdict   = OUT_ABSENT;
        end else begin
            n_phase     = st_phase;
            n_remaining = st_remaining;
            n_elen      = st_elen;
            n_verdict   = st_verdict;
        end
    end

    // results
    always_comb begin
        t_result pay;
        t_result summ;
        logic    has_pay;
        pay                = '0;
        pay.is_summary     = 1'b0;
        pay.data_byte      = i_byte;
        pay.outcome        = OUT_FOUND;
        summ               = '0;
        summ.is_summary    = 1'b1;
        summ.final_res     = 1'b1;
        priority if (st_phase == PH_BAD || st_remaining != 7'd0) begin
            summ.outcome = OUT_BAD;
        end else if (st_phase == PH_DONE && st_verdict == OUT_FOUND) begin
            summ.outcome        = OUT_FOUND;
            summ.payload_length = st_elen - 7'd1;
        end else begin
            summ.outcome = OUT_ABSENT;
        end
        has_pay   = (r_phase == PH_PAYLOAD);
        o_push.v0 = i_go && (has_pay || i_last);
        o_push.v1 = i_go && has_pay && i_last;
        o_push.r0 = has_pay ? pay : summ;
        o_push.r1 = summ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_remaining <= 7'd0;
            r_elen      <= 7'd0;
            r_verdict   <= OUT_ABSENT;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_elen      <= n_elen;
            r_verdict   <= n_verdict;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_last) |=> (r_phase == PH_LEN && r_remaining == 7'd0))
        else $error("record state not cleared after last byte");

    a_counting_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD || r_phase == PH_SKIP) |-> (r_remaining != 7'd0))
        else $error("element phase with nothing remaining");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.v0 && !o_push.r0.is_summary && o_push.r1.is_summary))
        else $error("payload and summary pushed out of order");
`endif

endmodule

// ===== rtl/ase_res_fifo.sv =====
// ----------------------------------------------------------------------------
// ase_res_fifo
// Small result queue taking up to two results per cycle, one out per cycle while the consumer is ready.
// ----------------------------------------------------------------------------
module ase_res_fifo
    import ase_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_slot [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr, wr_ptr1;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count, push_n;
    logic           pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_room  = (r_count <= CW'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_slot[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign wr_ptr1 = ptr_inc(r_wr_ptr);
    assign push_n  = CW'(i_push.v0) + CW'(i_push.v1);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push.v1) begin
            n_wr_ptr = ptr_inc(wr_ptr1);
        end else if (i_push.v0) begin
            n_wr_ptr = wr_ptr1;
        end
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + push_n - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_slot[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_slot[wr_ptr1] <= i_push.r1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> o_room)
        else $error("push without two free slots");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.v0) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("count not decremented on pop");
`endif

endmodule
